[sv/lens_distortion_correct_core_assert.svh]
// Assertion macros shared by the lens distortion correction RTL.
`ifndef LENS_DISTORTION_CORRECT_CORE_ASSERT_SVH
`define LENS_DISTORTION_CORRECT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LDC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LDC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ldc_pkg.sv]
// Shared types, constants and saturating add for the lens distortion corrector.
package ldc_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned DATA_W          = 64;
    localparam int unsigned CFG_IDX_W       = 4;

    localparam logic [DATA_W-1:0] S64_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S64_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X   = 4'd0,
        CFG_CENTER_Y   = 4'd1,
        CFG_RADIAL_C0  = 4'd2,
        CFG_RADIAL_C1  = 4'd3,
        CFG_RADIAL_C2  = 4'd4,
        CFG_RADIAL_C3  = 4'd5,
        CFG_TANGENT_C1 = 4'd6,
        CFG_TANGENT_C2 = 4'd7
    } t_cfg_idx;

    // 64-bit two's complement value with its saturation flag
    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } t_sat64;

    function automatic t_sat64 add_sat(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        t_sat64          r;
        s     = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        r.sat = s[DATA_W] ^ s[DATA_W-1];
        r.val = r.sat ? (s[DATA_W] ? S64_MIN : S64_MAX) : s[DATA_W-1:0];
        return r;
    endfunction

endpackage

[sv/ldc_mul.sv]
// Three-stage signed 64x64 multiplier with floor shift and 64-bit saturation.
module ldc_mul import ldc_pkg::*; #(
    parameter int unsigned SH = 10
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output t_sat64            o_p
);

    localparam int unsigned HW = DATA_W / 2;
    localparam int unsigned PW = 2 * DATA_W;

    // stage 1: partial products, low halves unsigned, high halves signed
    logic [DATA_W-1:0]        r_ll;
    logic signed [DATA_W:0]   r_lh;
    logic signed [DATA_W:0]   r_hl;
    logic signed [DATA_W-1:0] r_hh;
    // stage 2: middle terms combined
    logic signed [DATA_W+1:0] r_mid;
    logic [DATA_W-1:0]        r_ll2;
    logic [DATA_W-1:0]        r_hh2;
    // stage 3: result
    t_sat64                   r_p;

    logic [PW-1:0]            w_mid_ext;
    logic [PW-1:0]            w_full;
    logic signed [PW-1:0]     w_sh;
    logic                     w_fit;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= i_a[HW-1:0] * i_b[HW-1:0];
            r_lh  <= $signed({1'b0, i_a[HW-1:0]}) * $signed(i_b[DATA_W-1:HW]);
            r_hl  <= $signed(i_a[DATA_W-1:HW]) * $signed({1'b0, i_b[HW-1:0]});
            r_hh  <= $signed(i_a[DATA_W-1:HW]) * $signed(i_b[DATA_W-1:HW]);
            r_mid <= r_lh + r_hl;
            r_ll2 <= r_ll;
            r_hh2 <= r_hh;
        end
    end

    always_comb begin
        w_mid_ext = {{(PW-DATA_W-2){r_mid[DATA_W+1]}}, r_mid};
        w_full    = {r_hh2, r_ll2} + {w_mid_ext[PW-HW-1:0], {HW{1'b0}}};
        w_sh      = $signed(w_full) >>> SH;
        w_fit     = (&w_sh[PW-1:DATA_W-1]) | ~(|w_sh[PW-1:DATA_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p.sat <= ~w_fit;
            r_p.val <= w_fit ? w_sh[DATA_W-1:0] : (w_sh[PW-1] ? S64_MIN : S64_MAX);
        end
    end

    assign o_p = r_p;

endmodule

[sv/ldc_obuf.sv]
// Two-word output buffer that decouples the pipeline from the result receiver.
module ldc_obuf import ldc_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic                          i_clip,
    output logic                          o_full,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_cx,
    output logic signed [COORD_WIDTH-1:0] o_cy,
    output logic                          o_clip
);

    logic signed [COORD_WIDTH-1:0] r_cx   [2];
    logic signed [COORD_WIDTH-1:0] r_cy   [2];
    logic                          r_clip [2];
    logic                          r_wp;
    logic                          r_rp;
    logic [1:0]                    r_cnt;
    logic                          w_pop;

    assign w_pop   = (r_cnt != 2'd0) & i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cx    = r_cx[r_rp];
    assign o_cy    = r_cy[r_rp];
    assign o_clip  = r_clip[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cx[r_wp]   <= i_cx;
            r_cy[r_wp]   <= i_cy;
            r_clip[r_wp] <= i_clip;
        end
    end

endmodule

[sv/lens_distortion_correct_core.sv]
// Top level of the lens distortion corrector: 23-stage point pipeline plus output buffer.
// Input channel (i_in_valid / o_in_ready) takes one point word per clock while o_in_ready
// is high: point_x, point_y in signed Q11.20 mm. Output channel (o_out_valid / i_out_ready)
// returns one word per point, in order: corrected_x, corrected_y and the clipped flag.
// Configuration words (i_cfg_valid / o_cfg_ready, index plus 64-bit data) load the
// principal point and the radial / tangential coefficients; o_cfg_ready is always
// high. Write them only while no point is in flight.
// A point accepted at the input passes every register stage and then the output buffer
// before it shows on the output (pipelined 32-bit partial product multipliers set the depth).
// Throughput: one point per clock; every stage takes a new word each cycle unless the
// output buffer is full and the last stage holds a point.
// Reset (synchronous, active low) empties the pipeline and the output buffer and
// zeroes all coefficients, which puts the block in offset-only mode.
// A stalled receiver first fills the two-word output buffer; only then does the
// pipeline freeze and o_in_ready drop. Nothing is dropped or repeated.
`include "lens_distortion_correct_core_assert.svh"
module lens_distortion_correct_core import ldc_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_corrected_x,
    output logic signed [COORD_WIDTH-1:0] o_corrected_y,
    output logic                          o_clipped,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [DATA_W-1:0]             i_cfg_data
);

    localparam int unsigned CW   = COORD_WIDTH;
    localparam int unsigned XW   = CW + 1;          // offset-corrected point
    localparam int unsigned EXT  = DATA_W - XW;
    localparam int unsigned NSTG = 23;
    localparam int unsigned LAST = NSTG - 1;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    // ------------------------------------------------------------------
    // Stage map (stage number, then what that stage computes)
    //   0      xs, ys = point - centre
    //   1..3   x^2, y^2, x*y (>>10)
    //   4      r2, 2x^2, 2y^2, 2xy
    //   5      sx = r2 + 2x^2, sy = r2 + 2y^2
    //   5..8   four tangential products (>>90); 9: tx, ty
    //   4..8   c3*r2 (>>50) + c2 = a
    //   8..12  a*r2 (>>50) + c1 = b
    //   12..16 b*r2 (>>40) + c0 = dr
    //   16..19 xs*dr, ys*dr (>>60)
    //   20     dx (+ tx), dy (+ ty)
    //   21     xs + dx, ys + dy
    //   22     select bypass, clamp to coordinate range
    // ------------------------------------------------------------------

    // configuration registers
    logic signed [CW-1:0] r_center_x;
    logic signed [CW-1:0] r_center_y;
    logic [DATA_W-1:0]    r_rc0;
    logic [DATA_W-1:0]    r_rc1;
    logic [DATA_W-1:0]    r_rc2;
    logic [DATA_W-1:0]    r_rc3;
    logic [DATA_W-1:0]    r_tc1;
    logic [DATA_W-1:0]    r_tc2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_rc0      <= '0;
            r_rc1      <= '0;
            r_rc2      <= '0;
            r_rc3      <= '0;
            r_tc1      <= '0;
            r_tc2      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:   r_center_x <= i_cfg_data[CW-1:0];
                CFG_CENTER_Y:   r_center_y <= i_cfg_data[CW-1:0];
                CFG_RADIAL_C0:  r_rc0      <= i_cfg_data;
                CFG_RADIAL_C1:  r_rc1      <= i_cfg_data;
                CFG_RADIAL_C2:  r_rc2      <= i_cfg_data;
                CFG_RADIAL_C3:  r_rc3      <= i_cfg_data;
                CFG_TANGENT_C1: r_tc1      <= i_cfg_data;
                CFG_TANGENT_C2: r_tc2      <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: one shared advance, held only when the output
    // buffer is full and the last stage has a word to hand over.
    // ------------------------------------------------------------------
    logic             w_en;
    logic             w_acc;
    logic             w_full;
    logic             w_push;
    logic [LAST:0]    r_vld;

    assign w_en       = ~w_full | ~r_vld[LAST];
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid & w_en;
    assign w_push     = w_en & r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], w_acc};
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic signed [XW-1:0] n_xs;
    logic signed [XW-1:0] n_ys;
    logic signed [XW-1:0] r_xs [0:21];
    logic signed [XW-1:0] r_ys [0:21];

    logic [DATA_W-1:0] r_r2  [4:12];
    logic [DATA_W-1:0] r_xy2 [4:5];
    logic [DATA_W-1:0] r_x2d;
    logic [DATA_W-1:0] r_y2d;
    logic [DATA_W-1:0] r_sx;
    logic [DATA_W-1:0] r_sy;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_dr;
    logic [DATA_W-1:0] r_tx  [9:19];
    logic [DATA_W-1:0] r_ty  [9:19];
    logic [DATA_W-1:0] r_dx;
    logic [DATA_W-1:0] r_dy;
    logic [DATA_W-1:0] r_rx;
    logic [DATA_W-1:0] r_ry;
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic                 r_clip;

    // saturation seen so far, radial path and tangential path kept apart
    logic [21:0] r_rflg;
    logic [21:0] r_tflg;
    logic [21:0] w_rnew;
    logic [21:0] w_tnew;

    // sign-extended taps of the offset point
    logic [DATA_W-1:0] w_xs0, w_ys0, w_xs16, w_ys16, w_xs20, w_ys20, w_xs21, w_ys21;

    assign n_xs   = $signed({i_point_x[CW-1], i_point_x})
                  - $signed({r_center_x[CW-1], r_center_x});
    assign n_ys   = $signed({i_point_y[CW-1], i_point_y})
                  - $signed({r_center_y[CW-1], r_center_y});
    assign w_xs0  = {{EXT{r_xs[0][XW-1]}},  r_xs[0]};
    assign w_ys0  = {{EXT{r_ys[0][XW-1]}},  r_ys[0]};
    assign w_xs16 = {{EXT{r_xs[16][XW-1]}}, r_xs[16]};
    assign w_ys16 = {{EXT{r_ys[16][XW-1]}}, r_ys[16]};
    assign w_xs20 = {{EXT{r_xs[20][XW-1]}}, r_xs[20]};
    assign w_ys20 = {{EXT{r_ys[20][XW-1]}}, r_ys[20]};
    assign w_xs21 = {{EXT{r_xs[21][XW-1]}}, r_xs[21]};
    assign w_ys21 = {{EXT{r_ys[21][XW-1]}}, r_ys[21]};

    // ------------------------------------------------------------------
    // Multipliers, each three stages deep
    // ------------------------------------------------------------------
    t_sat64 w_x2, w_y2, w_xy;            // out at stage 3
    t_sat64 w_c3r;                       // out at stage 7
    t_sat64 w_t1sx, w_t2xy, w_t1xy, w_t2sy;  // out at stage 8
    t_sat64 w_ar;                        // out at stage 11
    t_sat64 w_br;                        // out at stage 15
    t_sat64 w_dxm, w_dym;                // out at stage 19

    ldc_mul #(.SH(10)) u_mul_x2 (.i_clk, .i_en(w_en), .i_a(w_xs0), .i_b(w_xs0), .o_p(w_x2));
    ldc_mul #(.SH(10)) u_mul_y2 (.i_clk, .i_en(w_en), .i_a(w_ys0), .i_b(w_ys0), .o_p(w_y2));
    ldc_mul #(.SH(10)) u_mul_xy (.i_clk, .i_en(w_en), .i_a(w_xs0), .i_b(w_ys0), .o_p(w_xy));

    ldc_mul #(.SH(50)) u_mul_c3r (
        .i_clk, .i_en(w_en), .i_a(r_rc3), .i_b(r_r2[4]), .o_p(w_c3r));
    ldc_mul #(.SH(50)) u_mul_ar (
        .i_clk, .i_en(w_en), .i_a(r_a), .i_b(r_r2[8]), .o_p(w_ar));
    ldc_mul #(.SH(40)) u_mul_br (
        .i_clk, .i_en(w_en), .i_a(r_b), .i_b(r_r2[12]), .o_p(w_br));
    ldc_mul #(.SH(60)) u_mul_dx (
        .i_clk, .i_en(w_en), .i_a(w_xs16), .i_b(r_dr), .o_p(w_dxm));
    ldc_mul #(.SH(60)) u_mul_dy (
        .i_clk, .i_en(w_en), .i_a(w_ys16), .i_b(r_dr), .o_p(w_dym));

    ldc_mul #(.SH(90)) u_mul_t1sx (
        .i_clk, .i_en(w_en), .i_a(r_tc1), .i_b(r_sx), .o_p(w_t1sx));
    ldc_mul #(.SH(90)) u_mul_t2xy (
        .i_clk, .i_en(w_en), .i_a(r_tc2), .i_b(r_xy2[5]), .o_p(w_t2xy));
    ldc_mul #(.SH(90)) u_mul_t1xy (
        .i_clk, .i_en(w_en), .i_a(r_tc1), .i_b(r_xy2[5]), .o_p(w_t1xy));
    ldc_mul #(.SH(90)) u_mul_t2sy (
        .i_clk, .i_en(w_en), .i_a(r_tc2), .i_b(r_sy), .o_p(w_t2sy));

    // ------------------------------------------------------------------
    // Saturating adders between the multipliers
    // ------------------------------------------------------------------
    t_sat64 n_r2, n_x2d, n_y2d, n_xy2;   // into stage 4
    t_sat64 n_sx, n_sy;                  // into stage 5
    t_sat64 n_a;                         // into stage 8
    t_sat64 n_tx, n_ty;                  // into stage 9
    t_sat64 n_b;                         // into stage 12
    t_sat64 n_dr;                        // into stage 16
    t_sat64 n_dxt, n_dyt;                // into stage 20
    t_sat64 n_rx, n_ry;                  // into stage 21

    logic   w_bypass;                    // radial c1 zero: offset only
    logic   w_tan_en;                    // tangential term switched on

    assign w_bypass = (r_rc1 == '0);
    assign w_tan_en = (r_tc1 != '0);

    always_comb begin
        n_r2  = add_sat(w_x2.val, w_y2.val);
        n_x2d = add_sat(w_x2.val, w_x2.val);
        n_y2d = add_sat(w_y2.val, w_y2.val);
        n_xy2 = add_sat(w_xy.val, w_xy.val);
        n_sx  = add_sat(r_r2[4], r_x2d);
        n_sy  = add_sat(r_r2[4], r_y2d);
        n_a   = add_sat(r_rc2, w_c3r.val);
        n_tx  = add_sat(w_t1sx.val, w_t2xy.val);
        n_ty  = add_sat(w_t1xy.val, w_t2sy.val);
        n_b   = add_sat(r_rc1, w_ar.val);
        n_dr  = add_sat(r_rc0, w_br.val);
        n_dxt = add_sat(w_dxm.val, r_tx[19]);
        n_dyt = add_sat(w_dym.val, r_ty[19]);
        n_rx  = add_sat(w_xs20, r_dx);
        n_ry  = add_sat(w_ys20, r_dy);
    end

    // flags raised by the logic that loads each stage
    always_comb begin
        w_rnew     = '0;
        w_tnew     = '0;
        w_rnew[4]  = w_x2.sat | w_y2.sat | w_xy.sat | n_r2.sat;
        w_tnew[4]  = n_x2d.sat | n_y2d.sat | n_xy2.sat;
        w_tnew[5]  = n_sx.sat | n_sy.sat;
        w_rnew[8]  = w_c3r.sat | n_a.sat;
        w_tnew[9]  = w_t1sx.sat | w_t2xy.sat | w_t1xy.sat | w_t2sy.sat
                   | n_tx.sat | n_ty.sat;
        w_rnew[12] = w_ar.sat | n_b.sat;
        w_rnew[16] = w_br.sat | n_dr.sat;
        w_rnew[20] = w_dxm.sat | w_dym.sat;
        w_tnew[20] = n_dxt.sat | n_dyt.sat;
        w_rnew[21] = n_rx.sat | n_ry.sat;
    end

    // ------------------------------------------------------------------
    // Final stage: bypass select and clamp to the coordinate range
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]    w_selx, w_sely;
    logic                 w_fitx, w_fity;
    logic signed [CW-1:0] n_cx, n_cy;
    logic                 n_clip;

    always_comb begin
        w_selx = w_bypass ? w_xs21 : r_rx;
        w_sely = w_bypass ? w_ys21 : r_ry;
        w_fitx = (&w_selx[DATA_W-1:CW-1]) | ~(|w_selx[DATA_W-1:CW-1]);
        w_fity = (&w_sely[DATA_W-1:CW-1]) | ~(|w_sely[DATA_W-1:CW-1]);
        n_cx   = w_fitx ? w_selx[CW-1:0] : (w_selx[DATA_W-1] ? C_MIN : C_MAX);
        n_cy   = w_fity ? w_sely[CW-1:0] : (w_sely[DATA_W-1] ? C_MIN : C_MAX);
        // tangential flags only count with the tangential term on
        n_clip = ~w_fitx | ~w_fity
               | (~w_bypass & (r_rflg[21] | (w_tan_en & r_tflg[21])));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xs[0] <= n_xs;
            r_ys[0] <= n_ys;
            for (int k = 1; k <= 21; k++) begin
                r_xs[k] <= r_xs[k-1];
                r_ys[k] <= r_ys[k-1];
            end
            r_rflg   <= {r_rflg[20:0], 1'b0} | w_rnew;
            r_tflg   <= {r_tflg[20:0], 1'b0} | w_tnew;

            r_r2[4]  <= n_r2.val;
            for (int k = 5; k <= 12; k++) begin
                r_r2[k] <= r_r2[k-1];
            end
            r_x2d    <= n_x2d.val;
            r_y2d    <= n_y2d.val;
            r_xy2[4] <= n_xy2.val;
            r_xy2[5] <= r_xy2[4];
            r_sx     <= n_sx.val;
            r_sy     <= n_sy.val;
            r_a      <= n_a.val;
            r_tx[9]  <= n_tx.val;
            r_ty[9]  <= n_ty.val;
            for (int k = 10; k <= 19; k++) begin
                r_tx[k] <= r_tx[k-1];
                r_ty[k] <= r_ty[k-1];
            end
            r_b      <= n_b.val;
            r_dr     <= n_dr.val;
            r_dx     <= w_tan_en ? n_dxt.val : w_dxm.val;
            r_dy     <= w_tan_en ? n_dyt.val : w_dym.val;
            r_rx     <= n_rx.val;
            r_ry     <= n_ry.val;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_clip   <= n_clip;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer
    // ------------------------------------------------------------------
    ldc_obuf #(.COORD_WIDTH(CW)) u_obuf (
        .i_clk,
        .i_rst_n,
        .i_push  (w_push),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_clip  (r_clip),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_cx    (o_corrected_x),
        .o_cy    (o_corrected_y),
        .o_clip  (o_clipped)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input is refused only while results are waiting at the output
    `LDC_ASSERT_IMP(a_ready_low_has_output, !o_in_ready, o_out_valid,
                    "input stalled with no result pending")
    // a frozen pipeline keeps every word in place
    `LDC_ASSERT_NXT(a_stall_keeps_words, !w_en, $stable(r_vld),
                    "pipeline word lost or moved during stall")
    // offset-only mode can clip only at the range limits
    `LDC_ASSERT_IMP(a_bypass_clip_at_limit, r_vld[LAST] && r_clip && w_bypass,
                    r_cx == C_MAX || r_cx == C_MIN || r_cy == C_MAX || r_cy == C_MIN,
                    "bypass clip without limit value")

endmodule
